// ----- src/rwl_pkg.sv -----
// Shared field widths, codes and word types of the reader-writer lock arbiter.
package rwl_pkg;

    localparam int MODE_W      = 3;
    localparam int ID_FIELD_W  = 6;
    localparam int STAT_W      = 3;
    localparam int CNT_FIELD_W = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Output word bit positions, lowest field first
    localparam int OUT_ID_LSB   = 0;
    localparam int OUT_STAT_LSB = OUT_ID_LSB + ID_FIELD_W;
    localparam int OUT_CNT_LSB  = OUT_STAT_LSB + STAT_W;
    localparam int OUT_WR_BIT   = OUT_CNT_LSB + CNT_FIELD_W;
    localparam int OUT_USED_W   = OUT_WR_BIT + 1;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [2:0]        t_op;
    typedef logic [STAT_W-1:0] t_status;

    // Request modes as they arrive on the bus
    localparam t_mode MODE_READ       = 3'd0;
    localparam t_mode MODE_TRY_READ   = 3'd1;
    localparam t_mode MODE_WRITE      = 3'd2;
    localparam t_mode MODE_TRY_WRITE  = 3'd3;
    localparam t_mode MODE_UNLOCK     = 3'd4;
    localparam t_mode MODE_CANCEL_RD  = 3'd5;
    localparam t_mode MODE_CANCEL_WR  = 3'd6;

    // Classified operations handed to the sequencer
    localparam t_op OP_READ      = 3'd0;
    localparam t_op OP_TRY_READ  = 3'd1;
    localparam t_op OP_WRITE     = 3'd2;
    localparam t_op OP_TRY_WRITE = 3'd3;
    localparam t_op OP_UNLOCK    = 3'd4;
    localparam t_op OP_CANCEL_RD = 3'd5;
    localparam t_op OP_CANCEL_WR = 3'd6;
    localparam t_op OP_INVALID   = 3'd7;

    localparam t_status ST_GRANTED    = 3'd0;
    localparam t_status ST_QUEUED     = 3'd1;
    localparam t_status ST_BUSY       = 3'd2;
    localparam t_status ST_QFULL      = 3'd3;
    localparam t_status ST_RELEASED   = 3'd4;
    localparam t_status ST_TIMED_OUT  = 3'd5;
    localparam t_status ST_CANCEL_LATE = 3'd6;
    localparam t_status ST_WOKEN      = 3'd7;

    typedef struct packed {
        t_op                   op;
        logic [ID_FIELD_W-1:0] id;
    } t_cmd;

    typedef struct packed {
        logic [ID_FIELD_W-1:0]  id;
        t_status                stat;
        logic [CNT_FIELD_W-1:0] cnt;
        logic                   wr;
        logic                   last;
    } t_res;

endpackage

// ----- src/write_preferring_rwlock_arbiter.sv -----
// Top level of the write-preferring reader-writer lock arbiter.
//
// Each slave word is one lock request from an agent: read lock, try read, write lock,
// try write, unlock, or cancel a timed-out read or write wait. Each request yields one
// or more master words: the first always answers the requester; woken grants (one
// writer, or up to READER_QUEUE_DEPTH readers in queue order) follow, and tlast marks
// the final word of the request. Every word of a request carries the holder counts as
// they stand after the whole request. Readers are refused or queued while a writer
// holds or waits; on release the oldest waiting writer wins, else all queued readers
// are woken up to MAX_READERS. A two-entry request queue decouples the slave side from
// the sequencer, and the output register lets a finished word wait for tready while
// the sequencer moves on. Steps: a request is taken in, then its answer is emitted; each
// woken agent adds a wait-queue memory read, then an emit; a cancel reads and compares
// each queue entry examined, reads and writes each entry moved up to close the gap, and
// finishes in a done state once it finds its entry. These steps follow from the
// single-port registered reads of the wait-queue memories. No clearing pass runs after
// reset: queue entries are only ever read below their fill counts.
module write_preferring_rwlock_arbiter
    import rwl_pkg::*;
#(
    parameter int READER_QUEUE_DEPTH = 16,
    parameter int WRITER_QUEUE_DEPTH = 16,
    parameter int ID_BITS            = 6,
    parameter int MAX_READERS        = 255
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // mode[2:0], requester_id[8:3], zeros above
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // target_id[5:0], status[8:6],
                                                // reader_count[16:9], writer_held[17]
    output logic                   o_m_tlast
);

    // Stored id width: ids are masked to ID_BITS, never wider than the field
    localparam int ID_W = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;

    logic cmd_valid, cmd_ready;
    t_cmd cmd;
    t_res res;

    rwl_front #(
        .ID_W (ID_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req_mode  (i_s_tdata[MODE_W-1:0]),
        .i_req_id    (i_s_tdata[MODE_W +: ID_FIELD_W]),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    rwl_back #(
        .RQD         (READER_QUEUE_DEPTH),
        .WQD         (WRITER_QUEUE_DEPTH),
        .ID_W        (ID_W),
        .MAX_READERS (MAX_READERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    // Pack the result word, lowest field first
    assign o_m_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), res.wr, res.cnt, res.stat, res.id};
    assign o_m_tlast = res.last;

endmodule

// ----- src/rwl_front.sv -----
// Request front end: decode the mode, mask the id and hold requests in a two-entry queue.
module rwl_front
    import rwl_pkg::*;
#(
    parameter int ID_W = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_mode                 i_req_mode,
    input  logic [ID_FIELD_W-1:0] i_req_id,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output t_cmd                  o_cmd
);

    localparam int FQ_DEPTH = 2;

    t_cmd       r_fq [FQ_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       push, pop;

    always_comb begin
        cls.id = ID_FIELD_W'(i_req_id[ID_W-1:0]);
        case (i_req_mode)
            MODE_READ:      cls.op = OP_READ;
            MODE_TRY_READ:  cls.op = OP_TRY_READ;
            MODE_WRITE:     cls.op = OP_WRITE;
            MODE_TRY_WRITE: cls.op = OP_TRY_WRITE;
            MODE_UNLOCK:    cls.op = OP_UNLOCK;
            MODE_CANCEL_RD: cls.op = OP_CANCEL_RD;
            MODE_CANCEL_WR: cls.op = OP_CANCEL_WR;
            default:        cls.op = OP_INVALID;
        endcase
    end

    assign o_req_ready = (r_cnt != 2'(FQ_DEPTH));
    assign push        = i_req_valid && o_req_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_fq[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fq[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/rwl_back.sv -----
// Lock sequencer: lock state, reader and writer wait queues, and result emission.
module rwl_back
    import rwl_pkg::*;
#(
    parameter int RQD         = 16,
    parameter int WQD         = 16,
    parameter int ID_W        = 6,
    parameter int MAX_READERS = 255
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    output logic o_cmd_ready,
    input  t_cmd i_cmd,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam int RQ_AW  = (RQD > 1) ? $clog2(RQD) : 1;
    localparam int RQ_CW  = $clog2(RQD + 1);
    localparam int WQ_AW  = (WQD > 1) ? $clog2(WQD) : 1;
    localparam int WQ_CW  = $clog2(WQD + 1);
    localparam int J_W    = (RQ_CW > WQ_CW) ? RQ_CW : WQ_CW;
    localparam int RH_W   = $clog2(MAX_READERS + 1);
    localparam int CMP_W  = (RH_W > RQ_CW) ? RH_W : RQ_CW;

    localparam logic [RQ_AW:0]    RQ_LIM  = (RQ_AW + 1)'(RQD);
    localparam logic [WQ_AW:0]    WQ_LIM  = (WQ_AW + 1)'(WQD);
    localparam logic [RQ_CW-1:0]  RQ_FULL = RQ_CW'(RQD);
    localparam logic [WQ_CW-1:0]  WQ_FULL = WQ_CW'(WQD);
    localparam logic [RH_W-1:0]   RH_MAX  = RH_W'(MAX_READERS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_REQ   = 4'd1;
    localparam logic [3:0] S_WRD   = 4'd2;
    localparam logic [3:0] S_WEMIT = 4'd3;
    localparam logic [3:0] S_RRD   = 4'd4;
    localparam logic [3:0] S_REMIT = 4'd5;
    localparam logic [3:0] S_SRD   = 4'd6;
    localparam logic [3:0] S_SCMP  = 4'd7;
    localparam logic [3:0] S_MRD   = 4'd8;
    localparam logic [3:0] S_MWR   = 4'd9;
    localparam logic [3:0] S_CDONE = 4'd10;

    localparam logic [1:0] FOL_NONE    = 2'd0;
    localparam logic [1:0] FOL_WRITER  = 2'd1;
    localparam logic [1:0] FOL_READERS = 2'd2;

    function automatic logic [RQ_AW-1:0] rq_pos(input logic [RQ_AW-1:0] head,
                                                 input logic [RQ_AW-1:0] off);
        logic [RQ_AW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= RQ_LIM) begin
            sum = sum - RQ_LIM;
        end
        return sum[RQ_AW-1:0];
    endfunction

    function automatic logic [WQ_AW-1:0] wq_pos(input logic [WQ_AW-1:0] head,
                                                 input logic [WQ_AW-1:0] off);
        logic [WQ_AW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= WQ_LIM) begin
            sum = sum - WQ_LIM;
        end
        return sum[WQ_AW-1:0];
    endfunction

    logic [ID_W-1:0] rq_mem [RQD];
    logic [ID_W-1:0] wq_mem [WQD];

    logic [3:0]       r_state, n_state;
    logic [RH_W-1:0]  r_rh, n_rh;
    logic             r_wr, n_wr;
    logic [RQ_AW-1:0] r_rq_head, n_rq_head;
    logic [RQ_CW-1:0] r_rc, n_rc;
    logic [WQ_AW-1:0] r_wq_head, n_wq_head;
    logic [WQ_CW-1:0] r_wc, n_wc;
    logic [ID_W-1:0]  r_id, n_id;
    t_status          r_stat, n_stat;
    logic [1:0]       r_fol, n_fol;
    logic [RQ_CW-1:0] r_nwake, n_nwake;
    logic             r_qsel, n_qsel;
    logic [J_W-1:0]   r_j, n_j;
    logic [ID_W-1:0]  r_rq_rdata, r_wq_rdata;
    logic             r_ov;
    t_res             r_res;

    logic             can_load, load;
    t_res             l_res;
    logic [RH_W-1:0]  base, avail;
    logic [RQ_CW-1:0] wake_n;
    logic [J_W-1:0]   cur_cnt, jp1, cnt_m1;
    logic             hit;
    logic             rq_re, rq_we, wq_re, wq_we, rq_push, wq_push;
    logic [RQ_AW-1:0] rq_raddr, rq_waddr;
    logic [WQ_AW-1:0] wq_raddr, wq_waddr;
    logic [ID_W-1:0]  rq_wdata, wq_wdata, cmd_id;
    logic             readers_ok, lock_free;

    assign cmd_id      = i_cmd.id[ID_W-1:0];
    assign o_cmd_ready = (r_state == S_IDLE);
    assign can_load    = !r_ov || i_res_ready;
    assign o_res_valid = r_ov;
    assign o_res       = r_res;

    assign readers_ok = !r_wr && (r_wc == '0);
    assign lock_free  = !r_wr && (r_rh == '0);

    // Readers that can be woken from a given holder count
    assign base   = (r_state == S_IDLE && !r_wr) ? r_rh - RH_W'(1) : r_rh;
    assign avail  = RH_MAX - base;
    assign wake_n = (CMP_W'(r_rc) < CMP_W'(avail)) ? r_rc : RQ_CW'(avail);

    assign cur_cnt = r_qsel ? J_W'(r_wc) : J_W'(r_rc);
    assign jp1     = r_j + J_W'(1);
    assign cnt_m1  = cur_cnt - J_W'(1);
    assign hit     = r_qsel ? (r_wq_rdata == r_id) : (r_rq_rdata == r_id);

    // Queue read ports
    always_comb begin
        rq_re    = (r_state == S_RRD) ||
                   (!r_qsel && (r_state == S_SRD || r_state == S_MRD));
        wq_re    = (r_state == S_WRD) ||
                   (r_qsel && (r_state == S_SRD || r_state == S_MRD));
        rq_raddr = rq_pos(r_rq_head, RQ_AW'(r_j));
        wq_raddr = wq_pos(r_wq_head, WQ_AW'(r_j));
        if (r_state == S_RRD) begin
            rq_raddr = r_rq_head;
        end else if (r_state == S_MRD) begin
            rq_raddr = rq_pos(r_rq_head, RQ_AW'(jp1));
        end
        if (r_state == S_WRD) begin
            wq_raddr = r_wq_head;
        end else if (r_state == S_MRD) begin
            wq_raddr = wq_pos(r_wq_head, WQ_AW'(jp1));
        end
    end

    // Queue write ports: push at the tail, or close the gap during a removal
    always_comb begin
        rq_we    = rq_push || (!r_qsel && r_state == S_MWR);
        wq_we    = wq_push || (r_qsel && r_state == S_MWR);
        rq_waddr = rq_push ? rq_pos(r_rq_head, RQ_AW'(r_rc)) : rq_pos(r_rq_head, RQ_AW'(r_j));
        wq_waddr = wq_push ? wq_pos(r_wq_head, WQ_AW'(r_wc)) : wq_pos(r_wq_head, WQ_AW'(r_j));
        rq_wdata = rq_push ? cmd_id : r_rq_rdata;
        wq_wdata = wq_push ? cmd_id : r_wq_rdata;
    end

    always_comb begin
        n_state   = r_state;
        n_rh      = r_rh;
        n_wr      = r_wr;
        n_rq_head = r_rq_head;
        n_rc      = r_rc;
        n_wq_head = r_wq_head;
        n_wc      = r_wc;
        n_id      = r_id;
        n_stat    = r_stat;
        n_fol     = r_fol;
        n_nwake   = r_nwake;
        n_qsel    = r_qsel;
        n_j       = r_j;
        rq_push   = 1'b0;
        wq_push   = 1'b0;
        load      = 1'b0;
        l_res.id   = ID_FIELD_W'(r_id);
        l_res.stat = r_stat;
        l_res.cnt  = CNT_FIELD_W'(r_rh);
        l_res.wr   = r_wr;
        l_res.last = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_id    = cmd_id;
                    n_fol   = FOL_NONE;
                    n_state = S_REQ;
                    case (i_cmd.op)
                        OP_READ: begin
                            if (readers_ok) begin
                                if (r_rh >= RH_MAX) begin
                                    n_stat = ST_BUSY;
                                end else begin
                                    n_rh   = r_rh + RH_W'(1);
                                    n_stat = ST_GRANTED;
                                end
                            end else if (r_rc >= RQ_FULL) begin
                                n_stat = ST_QFULL;
                            end else begin
                                rq_push = 1'b1;
                                n_rc    = r_rc + RQ_CW'(1);
                                n_stat  = ST_QUEUED;
                            end
                        end
                        OP_TRY_READ: begin
                            if (readers_ok && r_rh < RH_MAX) begin
                                n_rh   = r_rh + RH_W'(1);
                                n_stat = ST_GRANTED;
                            end else begin
                                n_stat = ST_BUSY;
                            end
                        end
                        OP_WRITE: begin
                            if (lock_free) begin
                                n_wr   = 1'b1;
                                n_stat = ST_GRANTED;
                            end else if (r_wc >= WQ_FULL) begin
                                n_stat = ST_QFULL;
                            end else begin
                                wq_push = 1'b1;
                                n_wc    = r_wc + WQ_CW'(1);
                                n_stat  = ST_QUEUED;
                            end
                        end
                        OP_TRY_WRITE: begin
                            if (lock_free) begin
                                n_wr   = 1'b1;
                                n_stat = ST_GRANTED;
                            end else begin
                                n_stat = ST_BUSY;
                            end
                        end
                        OP_UNLOCK: begin
                            n_stat = ST_RELEASED;
                            if (r_wr || r_rh != '0) begin
                                if (r_wc != '0) begin
                                    // Writer waits: hand over once nobody holds
                                    if (r_wr) begin
                                        n_fol = FOL_WRITER;
                                    end else begin
                                        n_rh = base;
                                        if (r_rh == RH_W'(1)) begin
                                            n_wr  = 1'b1;
                                            n_fol = FOL_WRITER;
                                        end
                                    end
                                end else begin
                                    n_wr    = 1'b0;
                                    n_rh    = base + RH_W'(wake_n);
                                    n_nwake = wake_n;
                                    n_fol   = (wake_n != '0) ? FOL_READERS : FOL_NONE;
                                end
                            end
                        end
                        OP_CANCEL_RD: begin
                            n_qsel = 1'b0;
                            n_j    = '0;
                            if (r_rc == '0) begin
                                n_stat = ST_CANCEL_LATE;
                            end else begin
                                n_state = S_SRD;
                            end
                        end
                        OP_CANCEL_WR: begin
                            n_qsel = 1'b1;
                            n_j    = '0;
                            if (r_wc == '0) begin
                                n_stat = ST_CANCEL_LATE;
                            end else begin
                                n_state = S_SRD;
                            end
                        end
                        default: begin
                            n_stat = ST_BUSY;
                        end
                    endcase
                end
            end
            S_REQ: begin
                if (can_load) begin
                    load       = 1'b1;
                    l_res.last = (r_fol == FOL_NONE);
                    case (r_fol)
                        FOL_WRITER:  n_state = S_WRD;
                        FOL_READERS: n_state = S_RRD;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_WRD: begin
                n_state = S_WEMIT;
            end
            S_WEMIT: begin
                if (can_load) begin
                    load       = 1'b1;
                    l_res.id   = ID_FIELD_W'(r_wq_rdata);
                    l_res.stat = ST_WOKEN;
                    n_wq_head  = wq_pos(r_wq_head, WQ_AW'(1));
                    n_wc       = r_wc - WQ_CW'(1);
                    n_state    = S_IDLE;
                end
            end
            S_RRD: begin
                n_state = S_REMIT;
            end
            S_REMIT: begin
                if (can_load) begin
                    load       = 1'b1;
                    l_res.id   = ID_FIELD_W'(r_rq_rdata);
                    l_res.stat = ST_WOKEN;
                    l_res.last = (r_nwake == RQ_CW'(1));
                    n_rq_head  = rq_pos(r_rq_head, RQ_AW'(1));
                    n_rc       = r_rc - RQ_CW'(1);
                    n_nwake    = r_nwake - RQ_CW'(1);
                    n_state    = (r_nwake == RQ_CW'(1)) ? S_IDLE : S_RRD;
                end
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (hit) begin
                    n_state = (r_j == cnt_m1) ? S_CDONE : S_MRD;
                end else if (r_j == cnt_m1) begin
                    n_stat  = ST_CANCEL_LATE;
                    n_state = S_REQ;
                end else begin
                    n_j     = jp1;
                    n_state = S_SRD;
                end
            end
            S_MRD: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                n_j     = jp1;
                n_state = (jp1 == cnt_m1) ? S_CDONE : S_MRD;
            end
            S_CDONE: begin
                n_stat  = ST_TIMED_OUT;
                n_state = S_REQ;
                if (!r_qsel) begin
                    n_rc = r_rc - RQ_CW'(1);
                end else begin
                    n_wc = r_wc - WQ_CW'(1);
                    // Last waiting writer gone: release the queued readers
                    if (r_wc == WQ_CW'(1) && !r_wr) begin
                        n_rh    = r_rh + RH_W'(wake_n);
                        n_nwake = wake_n;
                        n_fol   = (wake_n != '0) ? FOL_READERS : FOL_NONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rq_we) begin
            rq_mem[rq_waddr] <= rq_wdata;
        end
        if (rq_re) begin
            r_rq_rdata <= rq_mem[rq_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wq_we) begin
            wq_mem[wq_waddr] <= wq_wdata;
        end
        if (wq_re) begin
            r_wq_rdata <= wq_mem[wq_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_stat  <= n_stat;
        r_fol   <= n_fol;
        r_nwake <= n_nwake;
        r_qsel  <= n_qsel;
        r_j     <= n_j;
        if (load) begin
            r_res <= l_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rh      <= '0;
            r_wr      <= 1'b0;
            r_rq_head <= '0;
            r_rc      <= '0;
            r_wq_head <= '0;
            r_wc      <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rh      <= n_rh;
            r_wr      <= n_wr;
            r_rq_head <= n_rq_head;
            r_rc      <= n_rc;
            r_wq_head <= n_wq_head;
            r_wc      <= n_wc;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

// ----- src/rwl_checker.sv -----
// Port-level checks of the lock arbiter result stream, bound to the top level.
module rwl_checker
    import rwl_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tlast
);

    t_status                stat;
    logic                   wr;
    logic [CNT_FIELD_W-1:0] cnt;
    logic                   r_first;

    assign stat = o_m_tdata[OUT_STAT_LSB +: STAT_W];
    assign cnt  = o_m_tdata[OUT_CNT_LSB +: CNT_FIELD_W];
    assign wr   = o_m_tdata[OUT_WR_BIT];

    // Track whether the next word opens a new request's results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_m_tvalid && i_m_tready) begin
            r_first <= o_m_tlast;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result word changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(wr && cnt != '0))
        else $error("writer and readers hold the lock together");

    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_first |-> stat != ST_WOKEN)
        else $error("woken grant before the requester's answer");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && stat != ST_RELEASED && stat != ST_TIMED_OUT && stat != ST_WOKEN
        |-> o_m_tlast)
        else $error("single-answer status not marked last");

    a_wr_hand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && stat == ST_WOKEN && wr |-> o_m_tlast)
        else $error("writer handover not the final word");

endmodule

bind write_preferring_rwlock_arbiter rwl_checker u_rwl_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the write-preferring reader-writer lock arbiter.
`timescale 1ns / 1ps

module tb;
    import rwl_pkg::*;

    localparam int RD_DEPTH     = 16;
    localparam int WR_DEPTH     = 16;
    localparam int MAX_RD       = 255;
    localparam int RANDOM_ITEMS = 110;
    localparam int STALL_LIMIT  = 2000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 20;

    // Mode 7 is not a request; the arbiter answers it busy
    localparam t_mode MODE_UNUSED = 3'd7;

    typedef logic [ID_FIELD_W-1:0] t_agent;

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // mode, requester_id, zeros above
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;       // target_id, status, reader_count, writer_held
    logic                   o_m_tlast;

    // Hold both sides free of idling while set
    logic                   calm = 1'b0;

    int unsigned            errors = 0;
    int unsigned            stalled = 0;

    // Lock state as the arbiter should hold it
    int unsigned            rd_holders = 0;
    bit                     wr_owned = 1'b0;
    t_agent                 rd_wait_q[$];
    t_agent                 wr_wait_q[$];

    // Answers of the request being predicted, then the words still owed by the arbiter
    t_agent                 step_ids[$];
    t_status                step_stats[$];
    t_res                   pending_words[$];

    write_preferring_rwlock_arbiter #(
        .READER_QUEUE_DEPTH(RD_DEPTH),
        .WRITER_QUEUE_DEPTH(WR_DEPTH),
        .ID_BITS           (ID_FIELD_W),
        .MAX_READERS       (MAX_RD)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side about 7 percent of the time
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(99) >= 7);
    end

    // ---------------------------------------------------------------------
    // Lock predictor
    // ---------------------------------------------------------------------

    function automatic void answer(input t_agent id, input t_status st);
        step_ids.push_back(id);
        step_stats.push_back(st);
    endfunction

    // Wake queued readers oldest first, stopping at the reader limit
    function automatic void wake_readers();
        while (rd_wait_q.size() > 0 && rd_holders < MAX_RD) begin
            answer(rd_wait_q.pop_front(), ST_WOKEN);
            rd_holders++;
        end
    endfunction

    function automatic void hand_to_writer();
        answer(wr_wait_q.pop_front(), ST_WOKEN);
        wr_owned = 1'b1;
    endfunction

    // Drop the oldest waiter with this id from one of the queues; report whether found
    function automatic bit drop_waiter(input bit writers, input t_agent id);
        if (writers) begin
            foreach (wr_wait_q[k]) begin
                if (wr_wait_q[k] == id) begin
                    wr_wait_q.delete(k);
                    return 1'b1;
                end
            end
        end else begin
            foreach (rd_wait_q[k]) begin
                if (rd_wait_q[k] == id) begin
                    rd_wait_q.delete(k);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Apply one accepted request and queue the words it must produce
    function automatic void arbitrate(input t_mode mode, input t_agent id);
        bit   lock_free;
        bit   readers_ok;
        t_res w;
        step_ids.delete();
        step_stats.delete();
        lock_free  = (rd_holders == 0) && !wr_owned;
        readers_ok = !wr_owned && (wr_wait_q.size() == 0);
        case (mode)
            MODE_READ: begin
                if (readers_ok) begin
                    if (rd_holders >= MAX_RD) begin
                        answer(id, ST_BUSY);
                    end else begin
                        rd_holders++;
                        answer(id, ST_GRANTED);
                    end
                end else if (rd_wait_q.size() >= RD_DEPTH) begin
                    answer(id, ST_QFULL);
                end else begin
                    rd_wait_q.push_back(id);
                    answer(id, ST_QUEUED);
                end
            end
            MODE_TRY_READ: begin
                if (readers_ok && rd_holders < MAX_RD) begin
                    rd_holders++;
                    answer(id, ST_GRANTED);
                end else begin
                    answer(id, ST_BUSY);
                end
            end
            MODE_WRITE: begin
                if (lock_free) begin
                    wr_owned = 1'b1;
                    answer(id, ST_GRANTED);
                end else if (wr_wait_q.size() >= WR_DEPTH) begin
                    answer(id, ST_QFULL);
                end else begin
                    wr_wait_q.push_back(id);
                    answer(id, ST_QUEUED);
                end
            end
            MODE_TRY_WRITE: begin
                if (lock_free) begin
                    wr_owned = 1'b1;
                    answer(id, ST_GRANTED);
                end else begin
                    answer(id, ST_BUSY);
                end
            end
            MODE_UNLOCK: begin
                answer(id, ST_RELEASED);
                if (wr_owned) begin
                    wr_owned = 1'b0;
                    if (wr_wait_q.size() > 0) hand_to_writer();
                    else wake_readers();
                end else if (rd_holders > 0) begin
                    rd_holders--;
                    if (wr_wait_q.size() > 0) begin
                        if (rd_holders == 0) hand_to_writer();
                    end else begin
                        wake_readers();
                    end
                end
            end
            MODE_CANCEL_RD: begin
                answer(id, drop_waiter(1'b0, id) ? ST_TIMED_OUT : ST_CANCEL_LATE);
            end
            MODE_CANCEL_WR: begin
                if (drop_waiter(1'b1, id)) begin
                    answer(id, ST_TIMED_OUT);
                    // last waiting writer gone: do not strand the queued readers
                    if (wr_wait_q.size() == 0 && !wr_owned) wake_readers();
                end else begin
                    answer(id, ST_CANCEL_LATE);
                end
            end
            default: begin
                answer(id, ST_BUSY);
            end
        endcase
        // every word carries the holder counts as they stand after the whole request
        foreach (step_ids[k]) begin
            w.id   = step_ids[k];
            w.stat = step_stats[k];
            w.cnt  = rd_holders[CNT_FIELD_W-1:0];
            w.wr   = wr_owned;
            w.last = (k == step_ids.size() - 1);
            pending_words.push_back(w);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Result check and watchdog
    // ---------------------------------------------------------------------

    function automatic string show(input t_res w);
        return $sformatf("id=%0d status=%0d readers=%0d writer=%0d last=%0d",
                         w.id, w.stat, w.cnt, w.wr, w.last);
    endfunction

    always @(posedge i_clk) begin : check_words
        t_res got;
        t_res want;
        if (rst_n) begin
            if (o_m_tvalid && m_tready) begin
                got.id   = o_m_tdata[OUT_ID_LSB +: ID_FIELD_W];
                got.stat = o_m_tdata[OUT_STAT_LSB +: STAT_W];
                got.cnt  = o_m_tdata[OUT_CNT_LSB +: CNT_FIELD_W];
                got.wr   = o_m_tdata[OUT_WR_BIT];
                got.last = o_m_tlast;
                if (pending_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got %s",
                             $time, show(got));
                end else begin
                    want = pending_words.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: word mismatch, expected %s, got %s",
                                 $time, show(want), show(got));
                    end
                end
            end
            // drop the run when neither side has moved a word for too long
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
                stalled <= 0;
            end else if (stalled + 1 >= STALL_LIMIT) begin
                $display("FAIL write_preferring_rwlock_arbiter");
                $finish;
            end else begin
                stalled <= stalled + 1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------------

    // Present one request, wait for its handshake, then predict it. Valid stays high
    // into the next call unless that call opens a gap.
    task automatic send_request(input t_mode mode, input t_agent id);
        int unsigned gap;
        gap = (!calm && $urandom_range(99) < 7) ? $urandom_range(3, 1) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - MODE_W - ID_FIELD_W){1'b0}}, id, mode};
        do @(posedge i_clk); while (!o_s_tready);
        arbitrate(mode, id);
    endtask

    function automatic t_agent any_agent();
        return t_agent'($urandom_range(63));
    endfunction

    // Release every holder and waiter so the next test starts from a free lock
    task automatic release_all();
        while (wr_owned || rd_holders > 0 ||
               rd_wait_q.size() > 0 || wr_wait_q.size() > 0) begin
            if (wr_owned || rd_holders > 0) begin
                send_request(MODE_UNLOCK, any_agent());
            end else if (wr_wait_q.size() > 0) begin
                send_request(MODE_CANCEL_WR, wr_wait_q[0]);
            end else begin
                send_request(MODE_CANCEL_RD, rd_wait_q[0]);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Walk through every mode and the hand-over paths with chosen agents
    task automatic test_directed();
        send_request(MODE_TRY_READ, 6'd0);       // free lock: reader granted
        send_request(MODE_READ, 6'd63);          // second reader shares it
        send_request(MODE_TRY_WRITE, 6'd1);      // readers hold: busy
        send_request(MODE_WRITE, 6'd42);         // writer waits behind readers
        send_request(MODE_READ, 6'd21);          // writer waiting: reader queued
        send_request(MODE_TRY_READ, 6'd7);       // writer waiting: busy
        send_request(MODE_UNLOCK, 6'd0);         // one reader left, writer still waits
        send_request(MODE_UNLOCK, 6'd63);        // last reader out: hand to writer
        send_request(MODE_CANCEL_WR, 6'd9);      // nobody such waiting: too late
        send_request(MODE_CANCEL_RD, 6'd21);     // queued reader times out
        send_request(MODE_READ, 6'd21);
        send_request(MODE_WRITE, 6'd3);
        send_request(MODE_UNLOCK, 6'd42);        // writer to writer hand-over
        send_request(MODE_CANCEL_WR, 6'd3);      // already owns the lock: too late
        send_request(MODE_UNLOCK, 6'd3);         // no writer waits: wake the reader
        send_request(MODE_UNLOCK, 6'd21);
        send_request(MODE_UNLOCK, 6'd55);        // unlock with nothing held
        send_request(MODE_UNUSED, 6'd63);        // unused mode answers busy
        send_request(MODE_WRITE, 6'd4);
        send_request(MODE_READ, 6'd6);
        send_request(MODE_UNLOCK, 6'd4);         // wakes reader 6
        send_request(MODE_WRITE, 6'd8);
        send_request(MODE_READ, 6'd10);
        send_request(MODE_CANCEL_WR, 6'd8);      // last writer leaves: reader 10 woken
        send_request(MODE_UNLOCK, 6'd6);
        send_request(MODE_UNLOCK, 6'd10);
    endtask

    // Fill both wait queues past their depth, then release into a full wake burst
    task automatic test_queue_full();
        t_agent tail_id;
        send_request(MODE_WRITE, 6'd0);
        for (int i = 0; i < RD_DEPTH; i++) begin
            send_request(MODE_READ, t_agent'(i * 4 + $urandom_range(3)));
        end
        send_request(MODE_READ, any_agent());     // reader queue full
        // cancel the newest entry: search runs the whole queue
        tail_id = rd_wait_q[rd_wait_q.size() - 1];
        send_request(MODE_CANCEL_RD, tail_id);
        send_request(MODE_READ, any_agent());
        for (int i = 0; i <= WR_DEPTH; i++) begin
            send_request(MODE_WRITE, any_agent());  // last one finds the queue full
        end
        // each unlock passes to the next writer; the final one wakes all readers
        while (wr_owned || wr_wait_q.size() > 0) send_request(MODE_UNLOCK, any_agent());
        while (rd_holders > 0) send_request(MODE_UNLOCK, any_agent());
    endtask

    // Push the reader count to its maximum and check that waking stops there
    task automatic test_reader_limit();
        release_all();
        repeat (MAX_RD - 1) send_request(MODE_TRY_READ, any_agent());
        send_request(MODE_WRITE, 6'd17);
        repeat (3) send_request(MODE_READ, any_agent());
        send_request(MODE_TRY_READ, any_agent());
        send_request(MODE_CANCEL_WR, 6'd17);     // wakes one reader up to the limit
        send_request(MODE_TRY_READ, any_agent()); // at the limit: busy
        send_request(MODE_READ, any_agent());     // at the limit: busy, not queued
        send_request(MODE_UNLOCK, any_agent());   // one out, one more woken
        send_request(MODE_UNLOCK, any_agent());
    endtask

    // Weighted random requests; half the agents come from a small pool so that
    // cancels find their waiters. A middle stretch runs with no idling.
    task automatic test_random();
        int unsigned pick;
        t_mode       mode;
        t_agent      id;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm <= (n >= 35 && n < 75);
            pick = $urandom_range(99);
            if (pick < 22)      mode = MODE_READ;
            else if (pick < 32) mode = MODE_TRY_READ;
            else if (pick < 47) mode = MODE_WRITE;
            else if (pick < 55) mode = MODE_TRY_WRITE;
            else if (pick < 83) mode = MODE_UNLOCK;
            else if (pick < 90) mode = MODE_CANCEL_RD;
            else if (pick < 97) mode = MODE_CANCEL_WR;
            else                mode = MODE_UNUSED;
            id = $urandom_range(1) ? t_agent'($urandom_range(7)) : any_agent();
            send_request(mode, id);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        test_directed();
        test_queue_full();
        test_random();
        test_reader_limit();
        s_tvalid <= 1'b0;
        calm     <= 1'b0;
        // the watchdog bounds this wait
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS write_preferring_rwlock_arbiter");
        end else begin
            $display("FAIL write_preferring_rwlock_arbiter");
        end
        $finish;
    end

endmodule
